[rtl/ewd_pkg.sv]
// ----------------------------------------------------------------------------
// ewd_pkg: shared types and constants for the external watchdog
// Request and response items, register indexes and the timeout limit tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ewd_pkg;

   localparam int SEL_WIDTH   = 3;
   localparam int PULSE_WIDTH = 8;
   localparam int CSR_WIDTH   = 8;
   localparam int TDATA_WIDTH = 8;

   typedef enum logic [0:0] {
      CSR_DELAY_SELECT    = 1'b0,
      CSR_RESET_PULSE_LEN = 1'b1
   } csr_index_type;

   localparam logic [SEL_WIDTH-1:0]   DELAY_SELECT_RESET    = 3'd0;
   localparam logic [PULSE_WIDTH-1:0] RESET_PULSE_LEN_RESET = 8'd49;

   typedef struct packed {
      logic kick;
      logic fine_tick;
      logic coarse_tick;
   } req_type;

   typedef struct packed {
      logic timed_out;
      logic power_enabled;
      logic reset_asserted;
   } rsp_type;

   // limits fit in 7 bits, the narrowest width that holds the largest limit
   function automatic logic [6:0] major_limit(input logic [SEL_WIDTH-1:0] sel);
      logic [6:0] lim;
      case (sel)
         3'd0:    lim = 7'd7;
         3'd1:    lim = 7'd15;
         3'd2:    lim = 7'd22;
         3'd3:    lim = 7'd38;
         3'd4:    lim = 7'd76;
         3'd5:    lim = 7'd114;
         default: lim = 7'd57;
      endcase
      return lim;
   endfunction

   function automatic logic [6:0] minor_limit(input logic [SEL_WIDTH-1:0] sel);
      logic [6:0] lim;
      case (sel)
         3'd0:    lim = 7'd20;
         3'd1:    lim = 7'd8;
         3'd2:    lim = 7'd57;
         3'd3:    lim = 7'd9;
         3'd4:    lim = 7'd19;
         3'd5:    lim = 7'd28;
         3'd6:    lim = 7'd56;
         default: lim = 7'd113;
      endcase
      return lim;
   endfunction

endpackage

[rtl/external_watchdog_with_reset_pulse.sv]
// ----------------------------------------------------------------------------
// external_watchdog_with_reset_pulse: watchdog with reset pulse and power cut
// A request is registered in the input stage, then its response in the output register.
// Throughput: one request per cycle while the response is taken, set by the state update on each step.
// Reset clears counters, releases reset, enables power, restores registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module external_watchdog_with_reset_pulse #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [ewd_pkg::CSR_WIDTH-1:0]      csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [0] coarse_tick, [1] fine_tick, [2] kick, rest zero
   input  logic [ewd_pkg::TDATA_WIDTH-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] reset_asserted, [1] power_enabled, [2] timed_out, rest zero
   output logic [ewd_pkg::TDATA_WIDTH-1:0]    rsp_tdata
);
   import ewd_pkg::*;

   logic    in_valid_ff;
   req_type in_req_ff;
   logic    out_valid_ff;
   rsp_type out_rsp_ff;
   rsp_type step_rsp;
   logic    advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ewd_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .req       (in_req_ff),
      .rsp       (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_req_ff <= req_tdata[$bits(req_type)-1:0];
      end
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(out_rsp_ff);

endmodule

[rtl/ewd_core.sv]
// ----------------------------------------------------------------------------
// ewd_core: watchdog state and per-request update
// Holds counters, reset pulse and power state plus the two control registers,
// and computes the next state and response for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ewd_core #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  ewd_pkg::csr_index_type             csr_index,
   input  logic [ewd_pkg::CSR_WIDTH-1:0]      csr_wdata,
   input  logic                               step,
   input  ewd_pkg::req_type                   req,
   output ewd_pkg::rsp_type                   rsp
);
   import ewd_pkg::*;

   logic [SEL_WIDTH-1:0]   delay_select_ff;
   logic [PULSE_WIDTH-1:0] reset_pulse_len_ff;
   logic [COUNT_WIDTH-1:0] major_count_ff, major_count_in;
   logic [COUNT_WIDTH-1:0] minor_count_ff, minor_count_in;
   logic [PULSE_WIDTH-1:0] pulse_count_ff, pulse_count_in;
   logic                   fine_running_ff, fine_running_in;
   logic                   in_reset_ff, in_reset_in;
   logic                   power_on_ff, power_on_in;
   logic [COUNT_WIDTH-1:0] maj_lim, min_lim;
   logic                   timeout;

   assign maj_lim = COUNT_WIDTH'(major_limit(delay_select_ff));
   assign min_lim = COUNT_WIDTH'(minor_limit(delay_select_ff));

   always_comb begin
      major_count_in  = major_count_ff;
      minor_count_in  = minor_count_ff;
      pulse_count_in  = pulse_count_ff;
      fine_running_in = fine_running_ff;
      in_reset_in     = in_reset_ff;
      power_on_in     = power_on_ff;
      timeout         = 1'b0;

      if (req.coarse_tick) begin
         if (power_on_in && major_count_in < maj_lim) begin
            major_count_in = major_count_in + 1'b1;
         end
         if (major_count_in >= maj_lim) begin
            fine_running_in = 1'b1;
         end
      end

      if (req.fine_tick && fine_running_in) begin
         if (major_count_in >= maj_lim) begin
            minor_count_in = minor_count_in + 1'b1;
            if (minor_count_in >= min_lim) begin
               minor_count_in = '0;
               major_count_in = '0;
               in_reset_in    = 1'b1;
               power_on_in    = 1'b0;
               timeout        = 1'b1;
            end
         end
         if (in_reset_in) begin
            pulse_count_in = pulse_count_in + 1'b1;
            if (pulse_count_in == reset_pulse_len_ff) begin
               pulse_count_in = '0;
               in_reset_in    = 1'b0;
            end
         end
         if (!in_reset_in && power_on_in && major_count_in < maj_lim) begin
            fine_running_in = 1'b0;
         end
      end

      if (req.kick) begin
         major_count_in = '0;
         minor_count_in = '0;
         if (!in_reset_in) begin
            fine_running_in = 1'b0;
         end
         power_on_in = 1'b1;
      end

      rsp.reset_asserted = in_reset_in;
      rsp.power_enabled  = power_on_in;
      rsp.timed_out      = timeout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_select_ff    <= DELAY_SELECT_RESET;
         reset_pulse_len_ff <= RESET_PULSE_LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_SELECT:    delay_select_ff    <= csr_wdata[SEL_WIDTH-1:0];
            CSR_RESET_PULSE_LEN: reset_pulse_len_ff <= csr_wdata[PULSE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_count_ff  <= '0;
         minor_count_ff  <= '0;
         pulse_count_ff  <= '0;
         fine_running_ff <= 1'b0;
         in_reset_ff     <= 1'b0;
         power_on_ff     <= 1'b1;
      end else if (step) begin
         major_count_ff  <= major_count_in;
         minor_count_ff  <= minor_count_in;
         pulse_count_ff  <= pulse_count_in;
         fine_running_ff <= fine_running_in;
         in_reset_ff     <= in_reset_in;
         power_on_ff     <= power_on_in;
      end
   end

endmodule
